@@ design/lcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants for the LCS length engine.
// ----------------------------------------------------------------------------
package lcs_pkg;

	localparam int MAX_LEN_DEF     = 128;
	localparam int SYMBOL_BITS_DEF = 8;
	localparam int SYMBOL_PORT_W   = 8;
	localparam int LENGTH_PORT_W   = 8;

	typedef enum logic [1:0] {
		CMD_APPEND  = 2'd0,
		CMD_COMPARE = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// control broadcast from the top level to every cell
	typedef struct packed {
		logic adv;
		logic clear_row;
		logic clear_all;
		logic append;
	} cell_ctrl_t;

endpackage

@@ design/lcs_cell.sv @@
// ----------------------------------------------------------------------------
// lcs_cell
// One column of the score row: holds one first-string symbol and its score,
// updates the score for each passing symbol and hands the wavefront on.
// ----------------------------------------------------------------------------
module lcs_cell #(
	parameter int MAX_LEN     = lcs_pkg::MAX_LEN_DEF,
	parameter int SYMBOL_BITS = lcs_pkg::SYMBOL_BITS_DEF,
	parameter int IDX         = 0,
	parameter int SW          = $clog2(MAX_LEN + 1),
	parameter int IW          = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lcs_pkg::cell_ctrl_t    ctrl,
	input  logic [IW-1:0]          wr_idx,
	input  logic [SYMBOL_BITS-1:0] wr_sym,
	input  logic                   in_valid,
	input  logic                   in_last,
	input  logic [SYMBOL_BITS-1:0] in_sym,
	input  logic [SW-1:0]          in_up,
	input  logic [SW-1:0]          in_diag,
	output logic                   out_valid_q,
	output logic                   out_last_q,
	output logic [SYMBOL_BITS-1:0] out_sym_q,
	output logic [SW-1:0]          out_up_q,
	output logic [SW-1:0]          out_diag_q
);

	logic                   active_q;
	logic [SYMBOL_BITS-1:0] sym_q;
	logic [SW-1:0]          score_q;
	logic                   wr_here;
	logic                   step;
	logic [SW-1:0]          cur;

	assign wr_here = ctrl.append && (wr_idx == IW'(IDX));
	assign step    = ctrl.adv && in_valid;

	always_comb begin
		if (!active_q) begin
			cur = in_up;
		end else if (sym_q == in_sym) begin
			cur = in_diag + SW'(1);
		end else if (score_q > in_up) begin
			cur = score_q;
		end else begin
			cur = in_up;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			score_q     <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (ctrl.clear_all) begin
				active_q <= 1'b0;
			end else if (wr_here) begin
				active_q <= 1'b1;
			end
			if (ctrl.clear_row || ctrl.clear_all) begin
				score_q <= '0;
			end else if (step) begin
				score_q <= in_last ? '0 : cur;
			end
			if (ctrl.adv) begin
				out_valid_q <= in_valid;
				out_last_q  <= in_valid && in_last;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (wr_here) begin
			sym_q <= wr_sym;
		end
		if (step) begin
			out_sym_q  <= in_sym;
			out_up_q   <= cur;
			out_diag_q <= score_q;
		end
	end

endmodule

@@ design/lcs_length_engine_top.sv @@
// ----------------------------------------------------------------------------
// lcs_length_engine_top
// Longest common subsequence length over a systolic row of score cells.
// ----------------------------------------------------------------------------
// Compare symbols enter the cell row one per cycle and may follow each other
// back to back; each passes one cell per cycle. Both rates hold only while the
// row advances. The result of a string is registered at the output once its
// last symbol has left the last cell. Append and clear items are held off
// until no compare symbol is left in the row. A result not taken at the
// output holds the whole row until it is.
module lcs_length_engine_top #(
	parameter int MAX_LEN     = lcs_pkg::MAX_LEN_DEF,
	parameter int SYMBOL_BITS = lcs_pkg::SYMBOL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          cmd,
	input  logic [lcs_pkg::SYMBOL_PORT_W-1:0]   symbol,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lcs_pkg::LENGTH_PORT_W-1:0]   lcs_length,
	output logic                                first_truncated
);

	localparam int SW = $clog2(MAX_LEN + 1);
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int FW = $clog2(MAX_LEN + 2);
	localparam int RW = (SW > lcs_pkg::LENGTH_PORT_W) ? SW : lcs_pkg::LENGTH_PORT_W;

	lcs_pkg::cmd_t          cmd_in;
	lcs_pkg::cell_ctrl_t    ctrl;
	logic [SYMBOL_BITS-1:0] sym;
	logic [CW-1:0]          count_q;
	logic                   overflow_q;
	logic [FW-1:0]          inflight_q;
	logic                   out_valid_q;
	logic [lcs_pkg::LENGTH_PORT_W-1:0] length_q;
	logic                   trunc_q;
	logic                   busy;
	logic                   full;
	logic                   accept;
	logic                   enter;
	logic                   leave;
	logic                   set_overflow;
	logic [RW-1:0]          res_wide;
	logic [lcs_pkg::LENGTH_PORT_W-1:0] res_sat;

	logic [MAX_LEN:0]       lk_valid;
	logic [MAX_LEN:0]       lk_last;
	logic [SYMBOL_BITS-1:0] lk_sym  [MAX_LEN+1];
	logic [SW-1:0]          lk_up   [MAX_LEN+1];
	logic [SW-1:0]          lk_diag [MAX_LEN+1];

	generate
		if (SYMBOL_BITS <= lcs_pkg::SYMBOL_PORT_W) begin : g_sym_narrow
			assign sym = symbol[SYMBOL_BITS-1:0];
		end else begin : g_sym_wide
			assign sym = SYMBOL_BITS'(symbol);
		end
	endgenerate

	assign cmd_in = lcs_pkg::cmd_t'(cmd);
	assign busy   = (inflight_q != '0);
	assign full   = (count_q == CW'(MAX_LEN));

	always_comb begin
		ctrl.adv       = !out_valid_q || !out_stall;
		ctrl.clear_row = 1'b0;
		ctrl.clear_all = 1'b0;
		ctrl.append    = 1'b0;
		in_stall       = !ctrl.adv;
		enter          = 1'b0;
		set_overflow   = 1'b0;
		unique case (cmd_in) inside
			lcs_pkg::CMD_APPEND, lcs_pkg::CMD_CLEAR: begin
				if (busy) begin
					in_stall = 1'b1;
				end
			end
			default: begin
			end
		endcase
		accept = in_valid && !in_stall;
		if (accept) begin
			unique case (cmd_in)
				lcs_pkg::CMD_APPEND: begin
					ctrl.clear_row = 1'b1;
					ctrl.append    = !full;
					set_overflow   = full;
				end
				lcs_pkg::CMD_COMPARE: begin
					enter = 1'b1;
				end
				lcs_pkg::CMD_CLEAR: begin
					ctrl.clear_all = 1'b1;
				end
				lcs_pkg::CMD_NONE: begin
				end
			endcase
		end
	end

	// row input
	assign lk_valid[0] = enter;
	assign lk_last[0]  = last;
	assign lk_sym[0]   = sym;
	assign lk_up[0]    = '0;
	assign lk_diag[0]  = '0;

	generate
		for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
			lcs_cell #(
				.MAX_LEN     (MAX_LEN),
				.SYMBOL_BITS (SYMBOL_BITS),
				.IDX         (i),
				.SW          (SW),
				.IW          (IW)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.wr_idx      (count_q[IW-1:0]),
				.wr_sym      (sym),
				.in_valid    (lk_valid[i]),
				.in_last     (lk_last[i]),
				.in_sym      (lk_sym[i]),
				.in_up       (lk_up[i]),
				.in_diag     (lk_diag[i]),
				.out_valid_q (lk_valid[i+1]),
				.out_last_q  (lk_last[i+1]),
				.out_sym_q   (lk_sym[i+1]),
				.out_up_q    (lk_up[i+1]),
				.out_diag_q  (lk_diag[i+1])
			);
		end
	endgenerate

	assign leave    = ctrl.adv && lk_valid[MAX_LEN];
	assign res_wide = RW'(lk_up[MAX_LEN]);
	assign res_sat  = (res_wide > RW'(255)) ? lcs_pkg::LENGTH_PORT_W'(255)
	                                        : res_wide[lcs_pkg::LENGTH_PORT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			overflow_q  <= 1'b0;
			inflight_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.clear_all) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else begin
				if (ctrl.append) begin
					count_q <= count_q + CW'(1);
				end
				if (set_overflow) begin
					overflow_q <= 1'b1;
				end
			end
			if (enter && !leave) begin
				inflight_q <= inflight_q + FW'(1);
			end else if (leave && !enter) begin
				inflight_q <= inflight_q - FW'(1);
			end
			if (ctrl.adv) begin
				out_valid_q <= leave && lk_last[MAX_LEN];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (leave && lk_last[MAX_LEN]) begin
			length_q <= res_sat;
			trunc_q  <= overflow_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign lcs_length      = length_q;
	assign first_truncated = trunc_q;

endmodule

@@ test/tb_lcs_length_engine_top.sv @@
// ----------------------------------------------------------------------------
// tb_lcs_length_engine_top
// Self-checking bench for the LCS length engine: a directed table (empty and
// full first strings, sticky truncation, clear, unused command) followed by
// random string pairs, with random gaps and stalls on both channels and one
// long output hold that backs the engine up to its input.
// ----------------------------------------------------------------------------
module tb_lcs_length_engine_top;

	localparam int MAX_LEN     = lcs_pkg::MAX_LEN_DEF;
	localparam int RAND_ITEMS  = 1150;
	localparam int LONG_HOLD   = 600;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [7:0] len;
		logic       trunc;
	} lcs_res_t;

	typedef struct packed {
		lcs_pkg::cmd_t op;
		logic [7:0]    sym;
		logic          lst;
		int unsigned   reps;
		logic          typed;
		lcs_res_t      want;
	} dir_row_t;

	localparam int DIR_N = 24;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{lcs_pkg::CMD_COMPARE, 8'h00, 1'b1, 1,   1'b1, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_NONE,    8'hff, 1'b1, 1,   1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_APPEND,  8'h00, 1'b0, 1,   1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_APPEND,  8'hff, 1'b1, 1,   1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_COMPARE, 8'hff, 1'b0, 1,   1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_COMPARE, 8'h00, 1'b1, 1,   1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_COMPARE, 8'h00, 1'b1, 1,   1'b1, '{8'd1, 1'b0}},
		'{lcs_pkg::CMD_APPEND,  8'haa, 1'b0, 1,   1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_COMPARE, 8'h00, 1'b0, 1,   1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_COMPARE, 8'hff, 1'b0, 1,   1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_COMPARE, 8'haa, 1'b1, 1,   1'b1, '{8'd3, 1'b0}},
		'{lcs_pkg::CMD_CLEAR,   8'h55, 1'b1, 1,   1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_COMPARE, 8'h55, 1'b1, 1,   1'b1, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_APPEND,  8'h41, 1'b0, 130, 1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_COMPARE, 8'h41, 1'b0, 127, 1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_COMPARE, 8'h41, 1'b1, 1,   1'b1, '{8'd128, 1'b1}},
		'{lcs_pkg::CMD_COMPARE, 8'h42, 1'b1, 1,   1'b1, '{8'd0, 1'b1}},
		'{lcs_pkg::CMD_NONE,    8'h00, 1'b0, 1,   1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_CLEAR,   8'h00, 1'b0, 1,   1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_COMPARE, 8'h41, 1'b1, 1,   1'b1, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_APPEND,  8'h80, 1'b0, 1,   1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_APPEND,  8'h7f, 1'b0, 1,   1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_COMPARE, 8'h7f, 1'b0, 1,   1'b0, '{8'd0, 1'b0}},
		'{lcs_pkg::CMD_COMPARE, 8'h80, 1'b1, 1,   1'b0, '{8'd0, 1'b0}}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] cmd;
	logic [7:0] symbol;
	logic       last;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] lcs_length;
	logic       first_truncated;

	// predictor state
	logic [7:0]  stored_syms [MAX_LEN];
	int unsigned stored_len;
	int          row_score [MAX_LEN];
	logic        trunc_seen;

	lcs_res_t    pending_lengths [$];
	int unsigned mismatches;
	int unsigned items_in;
	int unsigned results_checked;
	int unsigned trunc_results;
	int unsigned longest_seen;
	int unsigned idle_cycles;
	int unsigned gap_pct;
	bit          calm;
	bit          long_hold_req;
	bit          long_hold_done;

	lcs_length_engine_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.symbol          (symbol),
		.last            (last),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.lcs_length      (lcs_length),
		.first_truncated (first_truncated)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void wipe_scores();
		for (int k = 0; k < MAX_LEN; k++)
			row_score[k] = 0;
	endfunction

	function automatic bit lcs_track_item(lcs_pkg::cmd_t op, logic [7:0] sym, logic lst,
			output lcs_res_t res);
		int diag;
		int up;
		int cur;
		int old;
		res = '0;
		case (op)
			lcs_pkg::CMD_APPEND: begin
				if (stored_len < MAX_LEN) begin
					stored_syms[stored_len] = sym;
					stored_len++;
				end else begin
					trunc_seen = 1'b1;
				end
				wipe_scores();
				return 1'b0;
			end
			lcs_pkg::CMD_CLEAR: begin
				stored_len = 0;
				trunc_seen = 1'b0;
				wipe_scores();
				return 1'b0;
			end
			lcs_pkg::CMD_COMPARE: begin
				diag = 0;
				up = 0;
				for (int k = 0; k < stored_len; k++) begin
					old = row_score[k];
					if (stored_syms[k] == sym)
						cur = diag + 1;
					else
						cur = (old > up) ? old : up;
					row_score[k] = cur;
					diag = old;
					up = cur;
				end
				if (!lst)
					return 1'b0;
				cur = (stored_len > 0) ? row_score[stored_len-1] : 0;
				res.len = (cur > 255) ? 8'd255 : cur[7:0];
				res.trunc = trunc_seen;
				wipe_scores();
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic offer_item(lcs_pkg::cmd_t op, logic [7:0] sym, logic lst, bit use_typed,
			lcs_res_t typed_res);
		lcs_res_t res;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cmd      <= op;
		symbol   <= sym;
		last     <= lst;
		do @(posedge clk); while (in_stall);
		if (op != lcs_pkg::CMD_NONE)
			items_in++;
		if (lcs_track_item(op, sym, lst, res))
			pending_lengths.push_back(use_typed ? typed_res : res);
	endtask

	function automatic logic [7:0] pick_sym(logic [7:0] base, bit wide);
		logic [7:0] s;
		s = wide ? 8'($urandom_range(0, 255)) : base + 8'($urandom_range(0, 3));
		return s;
	endfunction

	task automatic stream_random(int unsigned target);
		int unsigned start;
		int unsigned seq_no;
		int unsigned nfirst;
		int unsigned nstr;
		int unsigned slen;
		logic [7:0]  base;
		bit          wide;
		bit          drop_last;
		start = items_in;
		seq_no = 0;
		while (items_in - start < target) begin
			calm = (items_in - start > target - 150);
			if ($urandom_range(0, 3) == 0)
				gap_pct = $urandom_range(0, 2) * 15;
			base = 8'($urandom_range(0, 255));
			wide = ($urandom_range(0, 3) == 0);
			if (seq_no != 0 && $urandom_range(0, 9) == 0) begin
				// noise: any command, any fields
				repeat ($urandom_range(1, 4))
					offer_item(lcs_pkg::cmd_t'($urandom_range(0, 3)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
			end else begin
				if ($urandom_range(0, 4) == 0)
					offer_item(lcs_pkg::CMD_CLEAR, pick_sym(base, 1'b1),
						1'($urandom_range(0, 1)), 1'b0, '0);
				nfirst = ($urandom_range(0, 11) == 0) ? $urandom_range(100, 140)
					: $urandom_range(0, 12);
				repeat (nfirst)
					offer_item(lcs_pkg::CMD_APPEND, pick_sym(base, wide),
						1'($urandom_range(0, 1)), 1'b0, '0);
				if (seq_no == 0)
					long_hold_req = 1'b1;
				nstr = (seq_no == 0) ? 3 : $urandom_range(1, 3);
				repeat (nstr) begin
					slen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
						: $urandom_range(1, 10);
					drop_last = ($urandom_range(0, 19) == 0);
					for (int j = 1; j <= slen; j++)
						offer_item(lcs_pkg::CMD_COMPARE, pick_sym(base, wide),
							(j == slen) && !drop_last, 1'b0, '0);
				end
			end
			seq_no++;
		end
	endtask

	// stimulus
	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		cmd      = lcs_pkg::CMD_NONE;
		symbol   = '0;
		last     = 1'b0;
		stored_len = 0;
		trunc_seen = 1'b0;
		wipe_scores();
		mismatches = 0;
		items_in = 0;
		results_checked = 0;
		trunc_results = 0;
		longest_seen = 0;
		gap_pct = 10;
		calm = 1'b0;
		long_hold_req = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		for (int r = 0; r < DIR_N; r++)
			for (int k = 0; k < DIR_ROWS[r].reps; k++)
				offer_item(DIR_ROWS[r].op, DIR_ROWS[r].sym, DIR_ROWS[r].lst,
					DIR_ROWS[r].typed && (k == DIR_ROWS[r].reps - 1), DIR_ROWS[r].want);
		stream_random(RAND_ITEMS);
		calm = 1'b1;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_lengths.size() != 0)
			@(posedge clk);
		repeat (MAX_LEN + 20) @(posedge clk);
		$display("tb: %0d items in, %0d lengths checked (%0d with truncation, longest %0d)",
			items_in, results_checked, trunc_results, longest_seen);
		$display("tb: %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// output stall driver
	initial begin
		int unsigned stall_pct;
		stall_pct = 20;
		long_hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 255) == 0)
				stall_pct = $urandom_range(0, 2) * 20;
			if (long_hold_req && !long_hold_done) begin
				long_hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		lcs_res_t want;
		if (out_valid && !out_stall) begin
			results_checked++;
			if (first_truncated === 1'b1)
				trunc_results++;
			if (lcs_length > longest_seen)
				longest_seen = lcs_length;
			if (pending_lengths.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected result length %0d truncated %b",
						lcs_length, first_truncated);
			end else begin
				want = pending_lengths.pop_front();
				if (lcs_length !== want.len || first_truncated !== want.trunc) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: length exp %0d got %0d, truncated exp %b got %b",
							want.len, lcs_length, want.trunc, first_truncated);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: no progress for %0d cycles", STALL_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule

@@ files.f @@
design/lcs_pkg.sv
design/lcs_cell.sv
design/lcs_length_engine_top.sv
test/tb_lcs_length_engine_top.sv
